[rtl/hbm_pkg.sv]
// -----------------------------------------------------------------------------
// Hamming best-match package
// Shared types, codes and the popcount helpers of the descriptor matcher.
// -----------------------------------------------------------------------------
package hbm_pkg;

   localparam int DESC_W  = 256;
   localparam int WORD_W  = 64;
   localparam int POINT_W = 64;
   localparam int DIST_W  = 9;
   localparam int CFG_W   = 9;
   localparam int CSR_IDX_W = 1;
   localparam int PC_W    = 7;

   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_BOUND    = 1'd1;

   localparam logic [CFG_W-1:0] THRESHOLD_RESET = 9'd80;
   localparam logic [CFG_W-1:0] BOUND_RESET     = 9'd128;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FETCH,
      ST_RESP
   } hbm_state_type;

   // Status of the distance pipeline as seen by the sequencer.
   typedef struct packed {
      logic              busy;
      logic              valid;
      logic [DIST_W-1:0] distance;
   } hbm_dist_type;

   function automatic logic [3:0] pop8(input logic [7:0] v);
      logic [3:0] s;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         s = s + 4'(v[i]);
      end
      return s;
   endfunction

   function automatic logic [PC_W-1:0] pop64(input logic [WORD_W-1:0] v);
      logic [PC_W-1:0] s;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         s = s + PC_W'(pop8(v[i*8 +: 8]));
      end
      return s;
   endfunction

endpackage

[rtl/hbm_ref_mem.sv]
// -----------------------------------------------------------------------------
// Reference table memories
// One descriptor row and one point word per entry, synchronous read.
// -----------------------------------------------------------------------------
module hbm_ref_mem #(
   parameter int DEPTH = 1024,
   parameter int IDX_W = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [hbm_pkg::DESC_W-1:0]  wr_desc,
   input  logic [hbm_pkg::POINT_W-1:0] wr_point,
   input  logic                        desc_rd_en,
   input  logic [IDX_W-1:0]            desc_rd_addr,
   output logic                        desc_rd_valid,
   output logic [hbm_pkg::DESC_W-1:0]  desc_rd_data,
   input  logic                        pt_rd_en,
   input  logic [IDX_W-1:0]            pt_rd_addr,
   output logic [hbm_pkg::POINT_W-1:0] pt_rd_data
);
   import hbm_pkg::*;

   logic [DESC_W-1:0]  desc_mem [DEPTH];
   logic [POINT_W-1:0] pt_mem   [DEPTH];

   logic [DESC_W-1:0]  desc_rd_ff;
   logic [POINT_W-1:0] pt_rd_ff;
   logic               desc_rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         desc_mem[wr_addr] <= wr_desc;
         pt_mem[wr_addr]   <= wr_point;
      end
   end

   always_ff @(posedge clock) begin
      if (desc_rd_en) begin
         desc_rd_ff <= desc_mem[desc_rd_addr];
      end
      // The point read data holds until the next read, so a stalled result keeps it.
      if (pt_rd_en) begin
         pt_rd_ff <= pt_mem[pt_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_rd_valid_ff <= 1'b0;
      end else begin
         desc_rd_valid_ff <= desc_rd_en;
      end
   end

   assign desc_rd_valid = desc_rd_valid_ff;
   assign desc_rd_data  = desc_rd_ff;
   assign pt_rd_data    = pt_rd_ff;

endmodule

[rtl/hbm_dist_pipe.sv]
// -----------------------------------------------------------------------------
// Hamming distance pipeline
// XOR of query and reference row, per-word popcount, then the word sum.
// -----------------------------------------------------------------------------
module hbm_dist_pipe (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       query_load,
   input  logic [hbm_pkg::DESC_W-1:0] query_desc,
   input  logic                       ref_valid,
   input  logic [hbm_pkg::DESC_W-1:0] ref_desc,
   output hbm_pkg::hbm_dist_type      dist_out
);
   import hbm_pkg::*;

   localparam int NWORDS = DESC_W / WORD_W;

   logic [DESC_W-1:0] query_ff;
   logic [PC_W-1:0]   pc_ff [NWORDS];
   logic [PC_W-1:0]   pc_in [NWORDS];
   logic              pc_valid_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [DIST_W-1:0] dist_in;
   logic              dist_valid_ff;

   always_comb begin
      for (int w = 0; w < NWORDS; w++) begin
         pc_in[w] = pop64(query_ff[w*WORD_W +: WORD_W] ^ ref_desc[w*WORD_W +: WORD_W]);
      end
   end

   always_comb begin
      dist_in = '0;
      for (int w = 0; w < NWORDS; w++) begin
         dist_in = dist_in + DIST_W'(pc_ff[w]);
      end
   end

   always_ff @(posedge clock) begin
      if (query_load) begin
         query_ff <= query_desc;
      end
      if (ref_valid) begin
         pc_ff <= pc_in;
      end
      if (pc_valid_ff) begin
         dist_ff <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_valid_ff   <= 1'b0;
         dist_valid_ff <= 1'b0;
      end else begin
         pc_valid_ff   <= ref_valid;
         dist_valid_ff <= pc_valid_ff;
      end
   end

   assign dist_out.busy     = ref_valid | pc_valid_ff | dist_valid_ff;
   assign dist_out.valid    = dist_valid_ff;
   assign dist_out.distance = dist_ff;

endmodule

[rtl/hbm_seq.sv]
// -----------------------------------------------------------------------------
// Matcher sequencer
// Table fill count, scan control, running best and the result register.
// -----------------------------------------------------------------------------
module hbm_seq #(
   parameter int MAX_ENTRIES = 1024,
   parameter int IDX_W       = 10,
   parameter int CNT_W       = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_mode,
   input  logic [hbm_pkg::CFG_W-1:0]   match_threshold,
   input  logic [hbm_pkg::CFG_W-1:0]   search_bound,
   output logic                        query_load,
   output logic                        wr_en,
   output logic [IDX_W-1:0]            wr_addr,
   output logic                        desc_rd_en,
   output logic [IDX_W-1:0]            desc_rd_addr,
   output logic                        pt_rd_en,
   output logic [IDX_W-1:0]            pt_rd_addr,
   input  logic [hbm_pkg::POINT_W-1:0] pt_rd_data,
   input  hbm_pkg::hbm_dist_type       dist_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_matched,
   output logic [9:0]                  rsp_best_index,
   output logic [15:0]                 rsp_match_x,
   output logic [15:0]                 rsp_match_y,
   output logic signed [15:0]          rsp_match_norm_x,
   output logic signed [15:0]          rsp_match_norm_y
);
   import hbm_pkg::*;

   hbm_state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic              found_ff, found_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_matched_ff;
   logic [9:0]        rsp_index_ff;
   logic [POINT_W-1:0] rsp_point_ff;

   logic accept;
   logic scan_last;
   logic has_room;
   logic out_free;
   logic rsp_load;
   logic hit;
   logic [IDX_W+9:0] idx_ext;

   assign accept    = req_valid && !req_stall;
   assign scan_last = (CNT_W'(scan_idx_ff) + CNT_W'(1)) == count_ff;
   assign has_room  = count_ff < CNT_W'(MAX_ENTRIES);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign hit       = found_ff && (best_dist_ff < DIST_W'(match_threshold));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_QUERY) begin
               state_in = (count_ff == '0) ? ST_FETCH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!dist_in.busy) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall  = 1'b1;
      desc_rd_en = 1'b0;
      pt_rd_en   = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall  = 1'b0;
         ST_SCAN:  desc_rd_en = 1'b1;
         ST_DRAIN: ;
         ST_FETCH: pt_rd_en   = 1'b1;
         ST_RESP:  rsp_load   = out_free;
         default:  ;
      endcase
   end

   assign query_load   = accept && req_mode == MODE_QUERY;
   assign wr_en        = accept && req_mode == MODE_LOAD && has_room;
   assign wr_addr      = count_ff[IDX_W-1:0];
   assign desc_rd_addr = scan_idx_ff;
   assign pt_rd_addr   = best_idx_ff;

   // Table count, scan position and running best.
   always_comb begin
      count_in     = count_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      found_in     = found_ff;
      if (accept) begin
         case (req_mode)
            MODE_CLEAR: count_in = '0;
            MODE_LOAD: begin
               if (has_room) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            MODE_QUERY: begin
               scan_idx_in  = '0;
               cmp_idx_in   = '0;
               best_idx_in  = '0;
               best_dist_in = DIST_W'(search_bound);
               found_in     = 1'b0;
            end
            default: ;
         endcase
      end
      if (desc_rd_en) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end
      // Distances arrive in index order; only a strictly smaller one wins.
      if (dist_in.valid) begin
         cmp_idx_in = cmp_idx_ff + IDX_W'(1);
         if (dist_in.distance < best_dist_ff) begin
            best_dist_in = dist_in.distance;
            best_idx_in  = cmp_idx_ff;
            found_in     = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      found_ff     <= found_in;
   end

   assign idx_ext = {10'd0, best_idx_ff};

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_matched_ff <= hit;
         rsp_index_ff   <= hit ? idx_ext[9:0] : 10'd0;
         rsp_point_ff   <= hit ? pt_rd_data : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_matched      = rsp_matched_ff;
   assign rsp_best_index   = rsp_index_ff;
   assign rsp_match_x      = rsp_point_ff[15:0];
   assign rsp_match_y      = rsp_point_ff[31:16];
   assign rsp_match_norm_x = signed'(rsp_point_ff[47:32]);
   assign rsp_match_norm_y = signed'(rsp_point_ff[63:48]);

endmodule

[rtl/brief_hamming_best_match_unit.sv]
// -----------------------------------------------------------------------------
// Hamming best-match unit
// Brute-force nearest-neighbor search over a table of 256-bit descriptors.
// -----------------------------------------------------------------------------
// Usage: words enter on the req_ channel (req_valid, req_stall). A clear or
// load word is taken without a stall and gives no result; a load into a full
// table is dropped. A query word scans every stored entry, one memory row
// per cycle, and gives one rsp_ word: matched, the best index and the
// entry's points, or all zeros when nothing beats both the search bound
// and the match threshold. Ties keep the lowest index.
// A query holds req_stall high through its scan of the N stored entries;
// the single read port of the descriptor memory sets the scan at one
// entry per cycle. The scan is followed by the drain of the distance
// pipeline, the point lookup and the load of the result register, whose
// word shows on rsp_ in the cycle after. An empty table skips the scan and the drain.
// The result sits in an output register; while the receiver stalls it holds,
// and a finished query waits, with req_stall high, until the register is free.
// csr_ writes set match_threshold (index 0) and search_bound (index 1) and
// are to be made only while the unit is idle; the unit does not enforce it.
// Reset empties the table (the fill count goes to zero; no memory sweep is
// needed) and loads the threshold with 80 and the search bound with 128.
// -----------------------------------------------------------------------------
module brief_hamming_best_match_unit #(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [hbm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hbm_pkg::CFG_W-1:0]     csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_mode,
   input  logic [63:0]                   req_desc_word0,
   input  logic [63:0]                   req_desc_word1,
   input  logic [63:0]                   req_desc_word2,
   input  logic [63:0]                   req_desc_word3,
   input  logic [15:0]                   req_point_x,
   input  logic [15:0]                   req_point_y,
   input  logic signed [15:0]            req_norm_x,
   input  logic signed [15:0]            req_norm_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_matched,
   output logic [9:0]                    rsp_best_index,
   output logic [15:0]                   rsp_match_x,
   output logic [15:0]                   rsp_match_y,
   output logic signed [15:0]            rsp_match_norm_x,
   output logic signed [15:0]            rsp_match_norm_y
);
   import hbm_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   logic [CFG_W-1:0] match_threshold_ff;
   logic [CFG_W-1:0] search_bound_ff;

   logic [DESC_W-1:0]  req_desc;
   logic [POINT_W-1:0] req_point;

   logic               query_load;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic               desc_rd_en;
   logic [IDX_W-1:0]   desc_rd_addr;
   logic               desc_rd_valid;
   logic [DESC_W-1:0]  desc_rd_data;
   logic               pt_rd_en;
   logic [IDX_W-1:0]   pt_rd_addr;
   logic [POINT_W-1:0] pt_rd_data;
   hbm_dist_type       dist_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_threshold_ff <= THRESHOLD_RESET;
         search_bound_ff    <= BOUND_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MATCH_THRESHOLD: match_threshold_ff <= csr_write_data;
            CSR_SEARCH_BOUND:    search_bound_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign req_desc  = {req_desc_word3, req_desc_word2, req_desc_word1, req_desc_word0};
   assign req_point = {req_norm_y, req_norm_x, req_point_y, req_point_x};

   hbm_ref_mem #(
      .DEPTH (MAX_ENTRIES),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock         (clock),
      .reset         (reset),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_desc       (req_desc),
      .wr_point      (req_point),
      .desc_rd_en    (desc_rd_en),
      .desc_rd_addr  (desc_rd_addr),
      .desc_rd_valid (desc_rd_valid),
      .desc_rd_data  (desc_rd_data),
      .pt_rd_en      (pt_rd_en),
      .pt_rd_addr    (pt_rd_addr),
      .pt_rd_data    (pt_rd_data)
   );

   hbm_dist_pipe u_dist (
      .clock      (clock),
      .reset      (reset),
      .query_load (query_load),
      .query_desc (req_desc),
      .ref_valid  (desc_rd_valid),
      .ref_desc   (desc_rd_data),
      .dist_out   (dist_status)
   );

   hbm_seq #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .match_threshold  (match_threshold_ff),
      .search_bound     (search_bound_ff),
      .query_load       (query_load),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .desc_rd_en       (desc_rd_en),
      .desc_rd_addr     (desc_rd_addr),
      .pt_rd_en         (pt_rd_en),
      .pt_rd_addr       (pt_rd_addr),
      .pt_rd_data       (pt_rd_data),
      .dist_in          (dist_status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_matched      (rsp_matched),
      .rsp_best_index   (rsp_best_index),
      .rsp_match_x      (rsp_match_x),
      .rsp_match_y      (rsp_match_y),
      .rsp_match_norm_x (rsp_match_norm_x),
      .rsp_match_norm_y (rsp_match_norm_y)
   );

endmodule

[rtl/hbm_checker.sv]
// -----------------------------------------------------------------------------
// Hamming best-match checker
// Port-level properties of the matcher, bound to the top level.
// -----------------------------------------------------------------------------
module hbm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [1:0]                    req_mode,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_matched,
   input logic [9:0]                    rsp_best_index,
   input logic [15:0]                   rsp_match_x,
   input logic [15:0]                   rsp_match_y,
   input logic signed [15:0]            rsp_match_norm_x,
   input logic signed [15:0]            rsp_match_norm_y
);
   import hbm_pkg::*;

   // A stalled result word stays valid and keeps its match flag, index and x field.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_matched)
         && $stable(rsp_best_index) && $stable(rsp_match_x))
      else $error("stalled result word changed");

   // A miss reports all fields as zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_matched |-> rsp_best_index == 10'd0 && rsp_match_x == 16'd0
         && rsp_match_y == 16'd0 && rsp_match_norm_x == 16'sd0 && rsp_match_norm_y == 16'sd0)
      else $error("miss result carries nonzero fields");

   // A query occupies the unit, so the next word must wait.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode == MODE_QUERY |=> req_stall)
      else $error("word taken right after a query");

   // After a clear or load word, the input is free again in the next cycle.
   a_table_op_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode != MODE_QUERY |=> !req_stall)
      else $error("table operation stalled the input");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind brief_hamming_best_match_unit hbm_checker u_hbm_checker (.*);
